### src/tapered_straight_drive_heading_pd_defines.svh
// ----------------------------------------------------------------------------
// tapered straight drive assertion macros
// shared concurrent assertion forms for the drive controller
// ----------------------------------------------------------------------------
`ifndef TAPERED_STRAIGHT_DRIVE_HEADING_PD_DEFINES_SVH
`define TAPERED_STRAIGHT_DRIVE_HEADING_PD_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TSDH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TSDH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tsdh_pkg.sv
// ----------------------------------------------------------------------------
// tsdh_pkg
// constants and types for the tapered straight drive heading controller
// ----------------------------------------------------------------------------
package tsdh_pkg;

    localparam int WHEEL_COUNT  = 6;
    localparam int WHEEL_FIELDS = 6;
    localparam int WHEELS_USED  = (WHEEL_COUNT < WHEEL_FIELDS) ? WHEEL_COUNT : WHEEL_FIELDS;
    localparam int FIELD_W      = 24;
    localparam int WSUM_W       = 27;
    localparam int ROT_W        = 24;
    localparam int DIFF_W       = 25;

    // divide by ten as multiply by rounded-up reciprocal, exact below 2**26
    localparam int ROT_DIVISOR  = 10;
    localparam int ROT_SHIFT    = 29;
    localparam longint ROT_RECIP = ((64'd1 << ROT_SHIFT) + ROT_DIVISOR - 1) / ROT_DIVISOR;

    localparam int DONE_MARGIN  = 80;
    localparam int DRIVE_LIMIT  = 12000;
    localparam int DRIVE_W      = 15;
    localparam int GAIN_W       = 16;
    localparam int MAG_W        = 14;
    localparam int TICK_W       = 16;

    localparam int S_TDATA_W    = 240;
    localparam int M_TDATA_W    = 32;
    localparam int M_TUSER_W    = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int USER_DONE    = 0;
    localparam int USER_TIMEOUT = 1;

    localparam logic [MAG_W-1:0]  MAX_DRIVE_RESET = MAG_W'(12000);
    localparam logic [TICK_W-1:0] TIMEOUT_RESET   = TICK_W'(65535);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAPER_EN   = 3'd0,
        REG_TAPER_GAIN = 3'd1,
        REG_MAX_DRIVE  = 3'd2,
        REG_MIN_DRIVE  = 3'd3,
        REG_HEADING_KP = 3'd4,
        REG_HEADING_KD = 3'd5,
        REG_TIMEOUT    = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    typedef struct packed {
        action_t                   action;
        logic signed [FIELD_W-1:0] travel_target;
        logic signed [FIELD_W-1:0] heading_target;
        logic signed [FIELD_W-1:0] heading_after;
        logic signed [DIFF_W-1:0]  heading_chg;
        logic signed [ROT_W-1:0]   rot;
    } stage_t;

endpackage

### src/tapered_straight_drive_heading_pd.sv
// ----------------------------------------------------------------------------
// tapered_straight_drive_heading_pd
// straight drive with speed taper and pd heading hold, one item per tick
// ----------------------------------------------------------------------------
// two stages, the input register then the result register; both stall on m_tready
// one item per cycle unless stalled; the wheel sum and divide by ten sit before
// the input register, the gain multipliers and clamps before the result register
// reset (aresetn low, synchronous): pipeline empty, move not armed, goals and
// tick count zero, registers at their reset values (max 12000, timeout 65535)
`include "tapered_straight_drive_heading_pd_defines.svh"

module tapered_straight_drive_heading_pd (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cfg_index: register number, cfg_data: value (low bits used)
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsdh_pkg::CFG_DATA_W-1:0] cfg_data,
    // s_tdata from bit 0: travel_target, heading_target, heading_before,
    // heading_after, wheel_0 .. wheel_5 (24 bits each)
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsdh_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: action
    input  logic                            s_tuser,
    // m_tdata from bit 0: left_drive (15), right_drive (15), two zero bits
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsdh_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser from bit 0: done_res, timed_out
    output logic [tsdh_pkg::M_TUSER_W-1:0]  m_tuser
);
    import tsdh_pkg::*;

    // configuration
    logic                taper_en_reg;
    logic [GAIN_W-1:0]   taper_gain_reg;
    logic [MAG_W-1:0]    max_drive_reg;
    logic [MAG_W-1:0]    min_drive_reg;
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   kd_reg;
    logic [TICK_W-1:0]   timeout_reg;

    // move state
    logic signed [FIELD_W-1:0] goal_travel_reg, goal_travel_next;
    logic signed [FIELD_W-1:0] goal_heading_reg, goal_heading_next;
    logic                      backward_reg, backward_next;
    logic [TICK_W-1:0]         tick_count_reg, tick_count_next;
    logic                      armed_reg, armed_next;

    // pipeline
    stage_t stage_reg, stage_next;
    logic   in_valid_reg;
    logic   out_valid_reg;
    logic   advance;
    logic signed [DRIVE_W-1:0] left_reg, left_next;
    logic signed [DRIVE_W-1:0] right_reg, right_next;
    logic                      done_reg, done_next;
    logic                      timeout_flag_reg, timeout_flag_next;

    // input side
    logic signed [FIELD_W-1:0] wheel [WHEEL_FIELDS];
    logic signed [WSUM_W-1:0]  wheel_sum;
    logic [WSUM_W-1:0]         wsum_mag;
    logic [2*WSUM_W-1:0]       rot_prod;
    logic [ROT_W-2:0]          rot_mag;
    logic signed [FIELD_W-1:0] head_before_in;

    // tick side
    logic signed [DIFF_W-1:0]  remaining;
    logic [DIFF_W-1:0]         rem_mag;
    logic                      near_goal;
    logic                      timeout_hit;
    logic [DIFF_W+GAIN_W-1:0]  taper_prod;
    logic [DIFF_W+GAIN_W-9:0]  taper_mag;
    logic                      adj_neg;
    logic [MAG_W-1:0]          mag_hi, mag_lo, speed_mag;
    logic                      speed_neg;
    logic signed [MAG_W+1:0]   speed;
    logic signed [DIFF_W-1:0]  head_err;
    logic signed [41:0]        p_term, d_term, pd_raw;
    logic [41:0]               pd_raw_mag;
    logic signed [35:0]        pd, left_raw, right_raw;

    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [35:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v > 36'sd12000) begin
            r = DRIVE_W'(DRIVE_LIMIT);
        end else if (v < -36'sd12000) begin
            r = -DRIVE_W'(DRIVE_LIMIT);
        end else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    // wheel sum divided by ten and heading change, ahead of the input register
    always_comb begin
        for (int i = 0; i < WHEEL_FIELDS; i++) begin
            wheel[i] = s_tdata[4*FIELD_W + FIELD_W*i +: FIELD_W];
        end
        wheel_sum = '0;
        for (int i = 0; i < WHEELS_USED; i++) begin
            wheel_sum = wheel_sum + WSUM_W'(wheel[i]);
        end
        wsum_mag = wheel_sum[WSUM_W-1] ? WSUM_W'(-wheel_sum) : WSUM_W'(wheel_sum);
        rot_prod = (2*WSUM_W)'(wsum_mag) * (2*WSUM_W)'(ROT_RECIP);
        rot_mag  = rot_prod[ROT_SHIFT +: ROT_W-1];
        head_before_in = s_tdata[2*FIELD_W +: FIELD_W];

        stage_next.action         = action_t'(s_tuser);
        stage_next.travel_target  = s_tdata[0 +: FIELD_W];
        stage_next.heading_target = s_tdata[FIELD_W +: FIELD_W];
        stage_next.heading_after  = s_tdata[3*FIELD_W +: FIELD_W];
        stage_next.heading_chg    = DIFF_W'(signed'(s_tdata[3*FIELD_W +: FIELD_W]))
                                  - DIFF_W'(head_before_in);
        stage_next.rot = wheel_sum[WSUM_W-1] ? -signed'({1'b0, rot_mag})
                                             : signed'({1'b0, rot_mag});
    end

    // speed, taper and pd correction
    always_comb begin
        remaining   = DIFF_W'(goal_travel_reg) - DIFF_W'(stage_reg.rot);
        rem_mag     = remaining[DIFF_W-1] ? DIFF_W'(-remaining) : DIFF_W'(remaining);
        near_goal   = rem_mag < DIFF_W'(DONE_MARGIN);
        timeout_hit = tick_count_reg >= timeout_reg;

        taper_prod = (DIFF_W+GAIN_W)'(rem_mag) * (DIFF_W+GAIN_W)'(taper_gain_reg);
        taper_mag  = taper_prod[DIFF_W+GAIN_W-1:8];
        // direction-signed remaining is negative; a zero product counts positive
        adj_neg    = (backward_reg ? (remaining > 0) : (remaining < 0)) && (taper_mag != '0);
        mag_hi     = (taper_mag > (DIFF_W+GAIN_W-8)'(max_drive_reg)) ? max_drive_reg
                                                                     : taper_mag[MAG_W-1:0];
        mag_lo     = (mag_hi < min_drive_reg) ? min_drive_reg : mag_hi;
        speed_mag  = taper_en_reg ? mag_lo : max_drive_reg;
        speed_neg  = taper_en_reg ? (adj_neg ^ backward_reg) : backward_reg;
        speed      = speed_neg ? -signed'({2'b00, speed_mag}) : signed'({2'b00, speed_mag});

        head_err   = DIFF_W'(stage_reg.heading_after) - DIFF_W'(goal_heading_reg);
        p_term     = 42'(signed'({1'b0, kp_reg})) * 42'(head_err);
        d_term     = 42'(signed'({1'b0, kd_reg})) * 42'(stage_reg.heading_chg);
        pd_raw     = p_term + d_term;
        pd_raw_mag = pd_raw[41] ? 42'(-pd_raw) : 42'(pd_raw);
        pd         = pd_raw[41] ? -signed'(36'(pd_raw_mag[41:8]))
                                : signed'(36'(pd_raw_mag[41:8]));
        left_raw   = 36'(speed) - pd;
        right_raw  = 36'(speed) + pd;
    end

    // result and state update for the item in the input register
    always_comb begin
        goal_travel_next  = goal_travel_reg;
        goal_heading_next = goal_heading_reg;
        backward_next     = backward_reg;
        tick_count_next   = tick_count_reg;
        armed_next        = armed_reg;
        left_next         = '0;
        right_next        = '0;
        done_next         = 1'b1;
        timeout_flag_next = 1'b0;
        if (stage_reg.action == ACT_START) begin
            goal_travel_next  = stage_reg.travel_target;
            goal_heading_next = stage_reg.heading_target;
            backward_next     = stage_reg.travel_target < 0;
            tick_count_next   = '0;
            armed_next        = 1'b1;
            done_next         = 1'b0;
        end else if (!armed_reg) begin
            done_next = 1'b1;
        end else if (near_goal) begin
            armed_next = 1'b0;
        end else if (timeout_hit) begin
            armed_next        = 1'b0;
            timeout_flag_next = 1'b1;
        end else begin
            tick_count_next = tick_count_reg + TICK_W'(1);
            left_next       = sat_drive(left_raw);
            right_next      = sat_drive(right_raw);
            done_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taper_en_reg     <= 1'b0;
            taper_gain_reg   <= '0;
            max_drive_reg    <= MAX_DRIVE_RESET;
            min_drive_reg    <= '0;
            kp_reg           <= '0;
            kd_reg           <= '0;
            timeout_reg      <= TIMEOUT_RESET;
            goal_travel_reg  <= '0;
            goal_heading_reg <= '0;
            backward_reg     <= 1'b0;
            tick_count_reg   <= '0;
            armed_reg        <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TAPER_EN:   taper_en_reg   <= cfg_data[0];
                    REG_TAPER_GAIN: taper_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_MAX_DRIVE:  max_drive_reg  <= cfg_data[MAG_W-1:0];
                    REG_MIN_DRIVE:  min_drive_reg  <= cfg_data[MAG_W-1:0];
                    REG_HEADING_KP: kp_reg         <= cfg_data[GAIN_W-1:0];
                    REG_HEADING_KD: kd_reg         <= cfg_data[GAIN_W-1:0];
                    REG_TIMEOUT:    timeout_reg    <= cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                goal_travel_reg  <= goal_travel_next;
                goal_heading_reg <= goal_heading_next;
                backward_reg     <= backward_next;
                tick_count_reg   <= tick_count_next;
                armed_reg        <= armed_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stage_reg <= stage_next;
        end
        if (advance) begin
            left_reg         <= left_next;
            right_reg        <= right_next;
            done_reg         <= done_next;
            timeout_flag_reg <= timeout_flag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, right_reg, left_reg};
    assign m_tuser  = {timeout_flag_reg, done_reg};

    `TSDH_ASSERT_NOW(a_done_zero_drive, aclk, aresetn, out_valid_reg && done_reg, left_reg == '0 && right_reg == '0, "done item carries drive")
    `TSDH_ASSERT_NOW(a_timeout_is_done, aclk, aresetn, out_valid_reg && timeout_flag_reg, done_reg, "timeout without done")
    `TSDH_ASSERT_NEXT(a_start_arms, aclk, aresetn, advance && stage_reg.action == ACT_START, armed_reg && tick_count_reg == '0, "start did not arm the move")
    `TSDH_ASSERT_NOW(a_disarm_reports_done, aclk, aresetn, $fell(armed_reg) && $past(aresetn), out_valid_reg && done_reg, "move stopped without a done item")

endmodule

### dv/tapered_straight_drive_heading_pd_tb.sv
// ----------------------------------------------------------------------------
// tapered_straight_drive_heading_pd_tb
// drives start and tick items through the controller with random gaps on both
// streams, predicts every command in the bench and compares it field by field
// ----------------------------------------------------------------------------
module tapered_straight_drive_heading_pd_tb;
    import tsdh_pkg::*;

    typedef struct packed {
        action_t                              action;
        logic [WHEEL_FIELDS-1:0][FIELD_W-1:0] wheels;
        logic signed [FIELD_W-1:0]            head_after;
        logic signed [FIELD_W-1:0]            head_before;
        logic signed [FIELD_W-1:0]            heading_goal;
        logic signed [FIELD_W-1:0]            travel;
    } drive_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_mv;
        logic signed [DRIVE_W-1:0] right_mv;
        logic                      done;
        logic                      timed_out;
    } drive_cmd_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    tapered_straight_drive_heading_pd dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("** tapered_straight_drive_heading_pd: FAILED **");
        $finish;
    end

    // register mirror and move state of the predictor
    longint cfg_taper_on, cfg_taper_gain, cfg_max_mv, cfg_min_mv;
    longint cfg_kp, cfg_kd, cfg_timeout;
    longint move_goal, hold_heading, ticks_used;
    bit     move_reverse, move_armed;

    drive_item_t pending_items[$];
    drive_cmd_t  expected_cmds[$];
    int unsigned queued_total;
    int unsigned mismatches;
    bit          calm;

    drive_item_t cur_item;
    int unsigned send_gap;
    int unsigned ready_hold;

    initial begin
        cfg_taper_on   = 0;
        cfg_taper_gain = 0;
        cfg_max_mv     = 12000;
        cfg_min_mv     = 0;
        cfg_kp         = 0;
        cfg_kd         = 0;
        cfg_timeout    = 65535;
        move_goal      = 0;
        hold_heading   = 0;
        ticks_used     = 0;
        move_reverse   = 1'b0;
        move_armed     = 1'b0;
        queued_total   = 0;
        mismatches     = 0;
        calm           = 1'b0;
        send_gap       = 0;
        ready_hold     = 0;
    end

    // product scaled by 1/256, truncated toward zero
    function automatic longint div256(longint p);
        return (p < 0) ? -((-p) >>> 8) : (p >>> 8);
    endfunction

    function automatic longint clip_drive(longint v);
        if (v > DRIVE_LIMIT) return DRIVE_LIMIT;
        if (v < -DRIVE_LIMIT) return -DRIVE_LIMIT;
        return v;
    endfunction

    function automatic drive_cmd_t step_drive(drive_item_t it);
        drive_cmd_t cmd;
        longint     wsum, rem, rem_mag, dir, adj, mag, spd, pd, ha, hb;
        int         i;
        cmd = '0;
        if (it.action == ACT_START) begin
            move_goal    = longint'($signed(it.travel));
            hold_heading = longint'($signed(it.heading_goal));
            move_reverse = move_goal < 0;
            ticks_used   = 0;
            move_armed   = 1'b1;
            return cmd;
        end
        if (!move_armed) begin
            cmd.done = 1'b1;
            return cmd;
        end
        wsum = 0;
        for (i = 0; i < WHEELS_USED; i++) begin
            wsum += longint'($signed(it.wheels[i]));
        end
        rem     = move_goal - wsum / ROT_DIVISOR;
        rem_mag = (rem < 0) ? -rem : rem;
        // distance stop wins over the timeout
        if (rem_mag < DONE_MARGIN) begin
            move_armed = 1'b0;
            cmd.done   = 1'b1;
            return cmd;
        end
        if (ticks_used >= cfg_timeout) begin
            move_armed    = 1'b0;
            cmd.done      = 1'b1;
            cmd.timed_out = 1'b1;
            return cmd;
        end
        ticks_used++;
        dir = move_reverse ? -1 : 1;
        if (cfg_taper_on != 0) begin
            adj = div256(dir * rem * cfg_taper_gain);
            mag = (adj < 0) ? -adj : adj;
            if (mag > cfg_max_mv) mag = cfg_max_mv;
            // min clamp last, so it wins over max
            if (mag < cfg_min_mv) mag = cfg_min_mv;
            adj = (adj < 0) ? -mag : mag;
        end else begin
            adj = cfg_max_mv;
        end
        spd = dir * adj;
        ha  = longint'($signed(it.head_after));
        hb  = longint'($signed(it.head_before));
        pd  = div256(cfg_kp * (ha - hold_heading) + cfg_kd * (ha - hb));
        cmd.left_mv  = DRIVE_W'(clip_drive(spd - pd));
        cmd.right_mv = DRIVE_W'(clip_drive(spd + pd));
        return cmd;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic longint rnd(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic logic [FIELD_W-1:0] clamp24(longint v);
        if (v > 8388607) return FIELD_W'(8388607);
        if (v < -8388608) return FIELD_W'(-8388608);
        return FIELD_W'(v);
    endfunction

    function automatic void push_start(longint goal, longint heading);
        drive_item_t it;
        it              = '0;
        it.action       = ACT_START;
        it.travel       = clamp24(goal);
        it.heading_goal = clamp24(heading);
        pending_items.push_back(it);
        queued_total++;
    endfunction

    function automatic void push_tick(longint hb, longint ha, longint base, longint jitter);
        drive_item_t it;
        int          i;
        it             = '0;
        it.action      = ACT_TICK;
        it.head_before = clamp24(hb);
        it.head_after  = clamp24(ha);
        for (i = 0; i < WHEEL_FIELDS; i++) begin
            it.wheels[i] = clamp24(base + rnd(-jitter, jitter));
        end
        pending_items.push_back(it);
        queued_total++;
    endfunction

    // unconstrained item, any field pattern
    function automatic void push_noise();
        drive_item_t it;
        int          i;
        it              = '0;
        it.action       = action_t'($urandom_range(0, 1));
        it.travel       = FIELD_W'($urandom);
        it.heading_goal = FIELD_W'($urandom);
        it.head_before  = FIELD_W'($urandom);
        it.head_after   = FIELD_W'($urandom);
        for (i = 0; i < WHEEL_FIELDS; i++) begin
            it.wheels[i] = FIELD_W'($urandom);
        end
        pending_items.push_back(it);
        queued_total++;
    endfunction

    // well-formed move: a start then ticks closing on the goal
    function automatic void push_move();
        longint goal, hgoal, rot, hb, ha;
        longint n, k;
        case ($urandom_range(0, 9))
            0, 1, 2: goal = rnd(-300, 300);
            3, 4, 5, 6: goal = rnd(-30000, 30000);
            7: goal = 0;
            default: goal = rnd(-8388608, 8388607);
        endcase
        hgoal = ($urandom_range(0, 9) == 0) ? rnd(-8388608, 8388607) : rnd(-2000, 2000);
        n = rnd(1, 14);
        push_start(goal, hgoal);
        for (k = 1; k <= n; k++) begin
            rot = goal * k / n + rnd(-50, 50);
            if (k == n && $urandom_range(0, 1) == 1) rot = goal + rnd(-120, 120);
            if ($urandom_range(0, 19) == 0) rot = goal + rnd(-3000, 3000);
            hb = hgoal + rnd(-300, 300);
            ha = hb + rnd(-40, 40);
            if ($urandom_range(0, 19) == 0) begin
                hb = rnd(-8388608, 8388607);
                ha = rnd(-8388608, 8388607);
            end
            push_tick(hb, ha, rot * ROT_DIVISOR / WHEEL_FIELDS, rnd(0, 30));
        end
        // a trailing tick after the move has likely ended
        if ($urandom_range(0, 4) == 0) push_tick(hgoal, hgoal, goal * 10 / 6, 0);
    endfunction

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TAPER_EN:   cfg_taper_on   = val & 1;
            REG_TAPER_GAIN: cfg_taper_gain = val & 16'hFFFF;
            REG_MAX_DRIVE:  cfg_max_mv     = val & 16'h3FFF;
            REG_MIN_DRIVE:  cfg_min_mv     = val & 16'h3FFF;
            REG_HEADING_KP: cfg_kp         = val & 16'hFFFF;
            REG_HEADING_KD: cfg_kd         = val & 16'hFFFF;
            REG_TIMEOUT:    cfg_timeout    = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic program_regs(int unsigned ten, int unsigned gain, int unsigned maxd,
                                int unsigned mind, int unsigned kp, int unsigned kd,
                                int unsigned tmo);
        write_reg(REG_TAPER_EN, ten);
        write_reg(REG_TAPER_GAIN, gain);
        write_reg(REG_MAX_DRIVE, maxd);
        write_reg(REG_MIN_DRIVE, mind);
        write_reg(REG_HEADING_KP, kp);
        write_reg(REG_HEADING_KD, kd);
        write_reg(REG_TIMEOUT, tmo);
    endtask

    task automatic random_regs();
        int unsigned g, mx, mn, kp, kd, tmo;
        case ($urandom_range(0, 4))
            0: g = 0;
            1: g = 1;
            2: g = $urandom_range(1, 1024);
            3: g = $urandom_range(0, 65535);
            default: g = 65535;
        endcase
        case ($urandom_range(0, 2))
            0: mx = 0;
            1: mx = 12000;
            default: mx = $urandom_range(0, 12000);
        endcase
        case ($urandom_range(0, 3))
            0: mn = 0;
            1: mn = 12000;
            2: mn = $urandom_range(0, 3000);
            default: mn = $urandom_range(0, 12000);
        endcase
        kp = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 512) : $urandom_range(0, 65535);
        kd = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 512) : $urandom_range(0, 65535);
        case ($urandom_range(0, 4))
            0: tmo = 65535;
            1: tmo = $urandom_range(0, 15);
            2: tmo = $urandom_range(0, 1);
            default: tmo = $urandom_range(0, 65535);
        endcase
        program_regs($urandom_range(0, 1), g, mx, mn, kp, kd, tmo);
    endtask

    // returns at a falling edge once nothing is queued, offered or outstanding
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_cmds.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // item driver
    always @(posedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_cmds.push_back(step_drive(cur_item));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= {cur_item.wheels, cur_item.head_after, cur_item.head_before,
                                 cur_item.heading_goal, cur_item.travel};
                    s_tuser  <= cur_item.action;
                    next_valid = 1'b1;
                    send_gap   = pick_gap();
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // command monitor
    always @(posedge aclk) begin
        drive_cmd_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.left_mv   = m_tdata[DRIVE_W-1:0];
                got.right_mv  = m_tdata[2*DRIVE_W-1:DRIVE_W];
                got.done      = m_tuser[USER_DONE];
                got.timed_out = m_tuser[USER_TIMEOUT];
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected command: left %0d right %0d done %0b timeout %0b",
                                 got.left_mv, got.right_mv, got.done, got.timed_out);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp l %0d r %0d d %0b t %0b, got l %0d r %0d d %0b t %0b",
                                     want.left_mv, want.right_mv, want.done, want.timed_out,
                                     got.left_mv, got.right_mv, got.done, got.timed_out);
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) < 3) ready_hold = pick_gap();
            end
        end
    end

    initial begin
        int unsigned phase, target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: no taper, full drive, no heading hold
        push_tick(-8388608, 8388607, -8388608, 0);
        push_start(0, 0);
        push_tick(0, 0, 0, 0);
        push_start(8388607, -8388608);
        push_tick(-8388608, 8388607, 8388607, 0);
        push_tick(-8388608, 8388607, -8388608, 0);
        push_start(-8388608, 8388607);
        push_tick(8388607, 8388607, 0, 0);
        drain();

        // full gains, short timeout
        program_regs(1, 65535, 12000, 0, 65535, 65535, 2);
        push_start(1000, 0);
        push_tick(0, 100, 0, 0);
        push_tick(0, -100, 0, 0);
        push_tick(0, 0, 0, 0);
        push_start(-5000, 16);
        push_tick(16, 16, -8317, 0);
        push_start(-5000, 0);
        push_tick(0, 0, 0, 0);
        drain();

        // zero timeout gives up on the first tick
        program_regs(1, 0, 500, 3000, 256, 0, 0);
        push_start(20000, 0);
        push_tick(0, 0, 0, 0);
        drain();

        // minimum above maximum, zero taper taken as positive
        write_reg(REG_TIMEOUT, 65535);
        push_start(20000, 0);
        push_tick(0, 0, 0, 0);
        push_start(-300, 0);
        push_tick(0, 0, 0, 0);
        push_tick(0, 4, -1667, 0);
        drain();

        target = queued_total;
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 0) program_regs(1, 65535, 12000, 12000, 65535, 65535, 65535);
            else if (phase == 1) program_regs(0, 0, 0, 0, 0, 0, 0);
            else random_regs();
            calm = (phase % 3 == 1);
            target += 160;
            while (queued_total < target) begin
                case ($urandom_range(0, 9))
                    0: push_noise();
                    1: push_tick(rnd(-2000, 2000), rnd(-2000, 2000), rnd(-50000, 50000), 100);
                    default: push_move();
                endcase
            end
            drain();
        end

        repeat (6) @(posedge aclk);
        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("** tapered_straight_drive_heading_pd: PASSED **");
        end else begin
            $display("** tapered_straight_drive_heading_pd: FAILED **");
        end
        $finish;
    end

endmodule
